// ===== design/qrm_pkg.sv =====
package qrm_pkg;

	// nine entries of the row-major 3x3 matrix
	localparam int NUM_ENTRIES = 9;

	// entries on the main diagonal: 0, 4 and 8
	localparam logic [NUM_ENTRIES-1:0] DIAG_MASK = 9'b100010001;

	// control that travels beside the data through every stage
	typedef struct packed {
		logic                   valid;
		logic                   zero;
		logic [NUM_ENTRIES-1:0] neg;
	} qrm_ctl_t;

endpackage

// ===== design/qrm_quat_if.sv =====
interface qrm_quat_if #(
	parameter int COMPONENT_BITS = 16
);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] quat_w;
	logic signed [COMPONENT_BITS-1:0] quat_x;
	logic signed [COMPONENT_BITS-1:0] quat_y;
	logic signed [COMPONENT_BITS-1:0] quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== design/qrm_mat_if.sv =====
interface qrm_mat_if #(
	parameter int ENTRY_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ENTRY_BITS-1:0] row0_col0;
	logic signed [ENTRY_BITS-1:0] row0_col1;
	logic signed [ENTRY_BITS-1:0] row0_col2;
	logic signed [ENTRY_BITS-1:0] row1_col0;
	logic signed [ENTRY_BITS-1:0] row1_col1;
	logic signed [ENTRY_BITS-1:0] row1_col2;
	logic signed [ENTRY_BITS-1:0] row2_col0;
	logic signed [ENTRY_BITS-1:0] row2_col1;
	logic signed [ENTRY_BITS-1:0] row2_col2;
	logic                         zero_quaternion;

	modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
		row1_col2, row2_col0, row2_col1, row2_col2, zero_quaternion, input ready);
	modport sink (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
		row1_col2, row2_col0, row2_col1, row2_col2, zero_quaternion, output ready);
endinterface

// ===== design/quaternion_to_rotation_matrix.sv =====
// channel  modport  payload
// quat     sink     quat_w, quat_x, quat_y, quat_z (signed COMPONENT_BITS)
// matrix   source   row0_col0 .. row2_col2 (signed FRACTION_BITS+2), zero_quaternion
//
// one transaction per cycle sustained while matrix is not stalled; the stages are
// products, sums, FRACTION_BITS+2 long-division bit stages and round
// the long division, one quotient bit per stage for nine lanes, sets the depth
// arst_n clears every valid bit; payload registers are not reset
// a stall on matrix freezes the whole pipeline and drops quat.ready in the same cycle
module quaternion_to_rotation_matrix #(
	parameter int COMPONENT_BITS = 16,
	parameter int FRACTION_BITS  = 14
) (
	input  logic    clk,
	input  logic    arst_n,
	qrm_quat_if.sink  quat,
	qrm_mat_if.source matrix
);
	import qrm_pkg::*;

	localparam int NW = 2 * COMPONENT_BITS + 1;  // width of the norm
	localparam int QW = FRACTION_BITS + 2;       // raw quotient, up to 2^(F+1)
	localparam int EW = FRACTION_BITS + 2;       // output entry width
	localparam logic signed [EW-1:0] ONE = EW'(1) << FRACTION_BITS;

	// global advance: pipeline moves whenever the output slot is free or being taken
	logic en;
	logic out_valid;

	assign en         = !out_valid || matrix.ready;
	assign quat.ready = en;

	// stage 1 products, stage 2 norm and numerator magnitudes
	qrm_ctl_t                     ctl_d [QW+1];
	logic [NW-1:0]                n_d   [QW+1];
	logic [NUM_ENTRIES-1:0][NW-1:0] rem_d [QW+1];
	logic [NUM_ENTRIES-1:0][QW-1:0] q_d   [QW+1];

	qrm_front #(
		.CB(COMPONENT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (quat.valid),
		.w        (quat.quat_w),
		.x        (quat.quat_x),
		.y        (quat.quat_y),
		.z        (quat.quat_z),
		.ctl_s2   (ctl_d[0]),
		.n_s2     (n_d[0]),
		.mag_s2   (rem_d[0])
	);

	assign q_d[0] = '0;

	// floor(mag * 2^(F+1) / n), one bit per stage, msb first
	for (genvar g = 0; g < QW; g++) begin : g_div
		qrm_div_stage #(
			.NW   (NW),
			.QW   (QW),
			.FIRST(g == 0)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_d[g]),
			.n_in   (n_d[g]),
			.rem_in (rem_d[g]),
			.q_in   (q_d[g]),
			.ctl_s1 (ctl_d[g+1]),
			.n_s1   (n_d[g+1]),
			.rem_s1 (rem_d[g+1]),
			.q_s1   (q_d[g+1])
		);
	end

	// halve with rounding, clamp, sign, identity override for the all-zero input
	logic                           zero_out;
	logic [NUM_ENTRIES-1:0][EW-1:0] ent_out;

	qrm_back #(
		.FB(FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (ctl_d[QW]),
		.q_in     (q_d[QW]),
		.valid_s1 (out_valid),
		.zero_s1  (zero_out),
		.ent_s1   (ent_out)
	);

	assign matrix.valid           = out_valid;
	assign matrix.zero_quaternion = zero_out;
	assign matrix.row0_col0       = $signed(ent_out[0]);
	assign matrix.row0_col1       = $signed(ent_out[1]);
	assign matrix.row0_col2       = $signed(ent_out[2]);
	assign matrix.row1_col0       = $signed(ent_out[3]);
	assign matrix.row1_col1       = $signed(ent_out[4]);
	assign matrix.row1_col2       = $signed(ent_out[5]);
	assign matrix.row2_col0       = $signed(ent_out[6]);
	assign matrix.row2_col1       = $signed(ent_out[7]);
	assign matrix.row2_col2       = $signed(ent_out[8]);

`ifndef ASSERT_OFF
	// all-zero input gives exactly the identity
	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(matrix.valid && matrix.zero_quaternion) |->
		(matrix.row0_col0 == ONE && matrix.row1_col1 == ONE && matrix.row2_col2 == ONE &&
		matrix.row0_col1 == '0 && matrix.row1_col2 == '0 && matrix.row2_col0 == '0))
		else $error("zero quaternion did not give identity");

	// diagonal entries stay within plus or minus one
	a_diag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |->
		(matrix.row0_col0 <= ONE && matrix.row0_col0 >= -ONE &&
		matrix.row1_col1 <= ONE && matrix.row1_col1 >= -ONE &&
		matrix.row2_col2 <= ONE && matrix.row2_col2 >= -ONE))
		else $error("diagonal entry out of range");

	// off-diagonal entries row0_col1, row1_col0 and row2_col1 stay within plus or minus one
	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |->
		(matrix.row0_col1 <= ONE && matrix.row0_col1 >= -ONE &&
		matrix.row1_col0 <= ONE && matrix.row1_col0 >= -ONE &&
		matrix.row2_col1 <= ONE && matrix.row2_col1 >= -ONE))
		else $error("off-diagonal entry out of range");

	// a frozen pipeline keeps its last stage
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (out_valid && $stable(ent_out) && $stable(zero_out)))
		else $error("output stage changed during stall");
`endif

endmodule

// ===== design/qrm_front.sv =====
module qrm_front #(
	parameter int CB = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [CB-1:0]                  w,
	input  logic signed [CB-1:0]                  x,
	input  logic signed [CB-1:0]                  y,
	input  logic signed [CB-1:0]                  z,
	output qrm_pkg::qrm_ctl_t                     ctl_s2,
	output logic [2*CB:0]                         n_s2,
	output logic [qrm_pkg::NUM_ENTRIES-1:0][2*CB:0] mag_s2
);
	import qrm_pkg::*;

	localparam int PW = 2 * CB;
	localparam int NW = 2 * CB + 1;
	localparam int SW = 2 * CB + 3;

	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, xw_s1, yw_s1, zw_s1;
	logic                 valid_s1, zero_s1;

	// products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1   <= w * w;
			xx_s1   <= x * x;
			yy_s1   <= y * y;
			zz_s1   <= z * z;
			xy_s1   <= x * y;
			xz_s1   <= x * z;
			yz_s1   <= y * z;
			xw_s1   <= x * w;
			yw_s1   <= y * w;
			zw_s1   <= z * w;
			zero_s1 <= (w == '0) && (x == '0) && (y == '0) && (z == '0);
		end
	end

	// sums, numerators and magnitudes
	logic signed [SW-1:0] ww, xx, yy, zz, xy, xz, yz, xw, yw, zw, nsum;
	logic signed [SW-1:0] num [NUM_ENTRIES];

	always_comb begin
		ww = SW'(ww_s1);
		xx = SW'(xx_s1);
		yy = SW'(yy_s1);
		zz = SW'(zz_s1);
		xy = SW'(xy_s1);
		xz = SW'(xz_s1);
		yz = SW'(yz_s1);
		xw = SW'(xw_s1);
		yw = SW'(yw_s1);
		zw = SW'(zw_s1);
		nsum   = ww + xx + yy + zz;
		num[0] = ww + xx - yy - zz;
		num[1] = (xy - zw) <<< 1;
		num[2] = (xz + yw) <<< 1;
		num[3] = (xy + zw) <<< 1;
		num[4] = ww - xx + yy - zz;
		num[5] = (yz - xw) <<< 1;
		num[6] = (xz - yw) <<< 1;
		num[7] = (yz + xw) <<< 1;
		num[8] = ww - xx - yy + zz;
	end

	logic signed [SW-1:0] absv [NUM_ENTRIES];

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			absv[i] = num[i][SW-1] ? -num[i] : num[i];
		end
	end

	logic                   valid_s2;
	logic                   zero_s2;
	logic [NUM_ENTRIES-1:0] neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			n_s2    <= nsum[NW-1:0];
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				neg_s2[i] <= num[i][SW-1];
				mag_s2[i] <= absv[i][NW-1:0];
			end
		end
	end

	assign ctl_s2 = {valid_s2, zero_s2, neg_s2};

endmodule

// ===== design/qrm_div_stage.sv =====
module qrm_div_stage #(
	parameter int NW    = 33,
	parameter int QW    = 16,
	parameter bit FIRST = 1'b0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  qrm_pkg::qrm_ctl_t                      ctl_in,
	input  logic [NW-1:0]                          n_in,
	input  logic [qrm_pkg::NUM_ENTRIES-1:0][NW-1:0] rem_in,
	input  logic [qrm_pkg::NUM_ENTRIES-1:0][QW-1:0] q_in,
	output qrm_pkg::qrm_ctl_t                      ctl_s1,
	output logic [NW-1:0]                          n_s1,
	output logic [qrm_pkg::NUM_ENTRIES-1:0][NW-1:0] rem_s1,
	output logic [qrm_pkg::NUM_ENTRIES-1:0][QW-1:0] q_s1
);
	import qrm_pkg::*;

	// one quotient bit per lane, restoring
	logic [NW:0]    trial [NUM_ENTRIES];
	logic           ge    [NUM_ENTRIES];
	logic [NW:0]    diff  [NUM_ENTRIES];

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			trial[i] = FIRST ? {1'b0, rem_in[i]} : {rem_in[i], 1'b0};
			ge[i]    = trial[i] >= {1'b0, n_in};
			diff[i]  = trial[i] - {1'b0, n_in};
		end
	end

	logic                   valid_s1;
	logic                   zero_s1;
	logic [NUM_ENTRIES-1:0] neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= ctl_in.zero;
			neg_s1  <= ctl_in.neg;
			n_s1    <= n_in;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				rem_s1[i] <= ge[i] ? diff[i][NW-1:0] : trial[i][NW-1:0];
				q_s1[i]   <= {q_in[i][QW-2:0], ge[i]};
			end
		end
	end

	assign ctl_s1 = {valid_s1, zero_s1, neg_s1};

endmodule

// ===== design/qrm_back.sv =====
module qrm_back #(
	parameter int FB = 14
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  qrm_pkg::qrm_ctl_t                        ctl_in,
	input  logic [qrm_pkg::NUM_ENTRIES-1:0][FB+1:0]  q_in,
	output logic                                     valid_s1,
	output logic                                     zero_s1,
	output logic [qrm_pkg::NUM_ENTRIES-1:0][FB+1:0]  ent_s1
);
	import qrm_pkg::*;

	localparam int QW = FB + 2;
	localparam logic [QW-1:0] ONE = QW'(1) << FB;

	logic [QW:0]   rnd [NUM_ENTRIES];
	logic [QW-1:0] half [NUM_ENTRIES];
	logic [QW-1:0] sat [NUM_ENTRIES];
	logic [QW-1:0] val [NUM_ENTRIES];

	// round half away from zero on the magnitude, clamp, apply sign; identity for the all-zero input
	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			rnd[i]  = {1'b0, q_in[i]} + (QW+1)'(1);
			half[i] = rnd[i][QW:1];
			sat[i]  = (half[i] > ONE) ? ONE : half[i];
			if (ctl_in.zero) begin
				val[i] = DIAG_MASK[i] ? ONE : '0;
			end else begin
				val[i] = ctl_in.neg[i] ? -sat[i] : sat[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= ctl_in.zero;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				ent_s1[i] <= val[i];
			end
		end
	end

endmodule

// ===== bench/qrm_checker.sv =====
`timescale 1ns / 1ps

module qrm_checker (
	input  logic        clk,
	input  logic        arst_n,
	qrm_quat_if.sink    quat_mon,
	qrm_mat_if.sink     mat_mon,
	output int          errors,
	output int          pending
);
	typedef logic signed [15:0] entry_t;
	typedef struct {
		entry_t entry [qrm_pkg::NUM_ENTRIES];
		logic   zero;
	} rot_t;

	rot_t matrices_due [$];

	// exact ratio to q1.14, ties away from zero, clamped to one
	function automatic entry_t to_q14(longint num, longint n);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = ((mag <<< 15) + n) / (2 * n);
		if (q > 16384)
			q = 16384;
		return (num < 0) ? entry_t'(-q) : entry_t'(q);
	endfunction

	function automatic rot_t rotation_of(logic signed [15:0] qw, logic signed [15:0] qx,
		logic signed [15:0] qy, logic signed [15:0] qz);
		rot_t r;
		longint w, x, y, z, n;
		longint num [9];
		w = qw; x = qx; y = qy; z = qz;
		r.zero = (w == 0 && x == 0 && y == 0 && z == 0);
		if (r.zero) begin
			for (int i = 0; i < 9; i++)
				r.entry[i] = qrm_pkg::DIAG_MASK[i] ? entry_t'(16384) : entry_t'(0);
			return r;
		end
		n = w*w + x*x + y*y + z*z;
		num[0] = w*w + x*x - y*y - z*z;
		num[1] = 2 * (x*y - z*w);
		num[2] = 2 * (x*z + y*w);
		num[3] = 2 * (x*y + z*w);
		num[4] = w*w - x*x + y*y - z*z;
		num[5] = 2 * (y*z - x*w);
		num[6] = 2 * (x*z - y*w);
		num[7] = 2 * (y*z + x*w);
		num[8] = w*w - x*x - y*y + z*z;
		for (int i = 0; i < 9; i++)
			r.entry[i] = to_q14(num[i], n);
		return r;
	endfunction

	assign pending = matrices_due.size();

	always @(posedge clk or negedge arst_n) begin
		rot_t got, exp_m;
		bit bad;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (quat_mon.valid && quat_mon.ready)
				matrices_due.push_back(rotation_of(quat_mon.quat_w, quat_mon.quat_x,
					quat_mon.quat_y, quat_mon.quat_z));
			if (mat_mon.valid && mat_mon.ready) begin
				got.entry[0] = mat_mon.row0_col0; got.entry[1] = mat_mon.row0_col1;
				got.entry[2] = mat_mon.row0_col2; got.entry[3] = mat_mon.row1_col0;
				got.entry[4] = mat_mon.row1_col1; got.entry[5] = mat_mon.row1_col2;
				got.entry[6] = mat_mon.row2_col0; got.entry[7] = mat_mon.row2_col1;
				got.entry[8] = mat_mon.row2_col2; got.zero = mat_mon.zero_quaternion;
				if (matrices_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected matrix transaction at %0t", $time);
					errors <= errors + 1;
				end else begin
					exp_m = matrices_due.pop_front();
					bad = (got.zero !== exp_m.zero);
					for (int i = 0; i < 9; i++)
						if (got.entry[i] !== exp_m.entry[i])
							bad = 1;
					if (bad) begin
						if (errors < 10) begin
							$display("matrix mismatch at %0t, zero exp %0b got %0b",
								$time, exp_m.zero, got.zero);
							for (int i = 0; i < 9; i++)
								$display("  entry %0d exp %0d got %0d",
									i, exp_m.entry[i], got.entry[i]);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	localparam int RANDOM_QUATS = 680;
	localparam int IDLE_LIMIT   = 5000;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending;
	int   idle_cycles = 0;
	bit   stim_done = 0;
	bit   hold_off = 0;

	qrm_quat_if #(.COMPONENT_BITS(16)) quat ();
	qrm_mat_if  #(.ENTRY_BITS(16))     matrix ();

	quaternion_to_rotation_matrix dut (
		.clk(clk), .arst_n(arst_n), .quat(quat.sink), .matrix(matrix.source)
	);

	qrm_checker chk (
		.clk(clk), .arst_n(arst_n), .quat_mon(quat.sink), .mat_mon(matrix.sink),
		.errors(errors), .pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		quat.valid = 0;
		quat.quat_w = 0; quat.quat_x = 0; quat.quat_y = 0; quat.quat_z = 0;
		matrix.ready = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// component mix: extremes, small values and full range
	function automatic logic [15:0] pick_component();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3: return 0;
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one quaternion and hold it until the transaction completes
	task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		quat.valid <= 1;
		quat.quat_w <= w; quat.quat_x <= x; quat.quat_y <= y; quat.quat_z <= z;
		do @(posedge clk); while (!quat.ready);
	endtask

	task automatic idle_quat(int cycles);
		if (cycles > 0) begin
			quat.valid <= 0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// sender: directed corners, random corner mixes, then random bursts with gaps
	initial begin
		static logic [15:0] corner [6] = '{16'sh8000, 16'sh7fff, 0, 1, 16'hffff, 16'sh4000};
		@(posedge clk iff arst_n);
		@(posedge clk);
		send_quat(0, 0, 0, 0);
		send_quat(1, 0, 0, 0);
		send_quat(0, 1, 0, 0);
		send_quat(0, 0, 1, 0);
		send_quat(0, 0, 0, 1);
		send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_quat(16'sh8000, 0, 0, 0);
		send_quat(0, 16'sh7fff, 16'sh8000, 0);
		send_quat(1, 1, 0, 0);
		send_quat(16'hffff, 1, 16'hffff, 1);
		send_quat(3, 0, 0, 1);
		for (int i = 0; i < 12; i++)
			send_quat(corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)],
				corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)]);
		send_quat(0, 0, 0, 0);
		// long receiver hold-off while the sender keeps offering
		hold_off <= 1;
		for (int i = 0; i < 40; i++)
			send_quat(pick_component(), pick_component(), pick_component(), pick_component());
		for (int n = 0; n < RANDOM_QUATS; ) begin
			int burst;
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst && n < RANDOM_QUATS; b++, n++)
				send_quat(pick_component(), pick_component(), pick_component(),
					pick_component());
			if ($urandom_range(0, 3) != 0)
				idle_quat($urandom_range(1, 12));
		end
		quat.valid <= 0;
		stim_done <= 1;
	end

	// receiver stall pattern and the one long hold-off
	initial begin
		int mode;
		@(posedge clk iff arst_n);
		matrix.ready <= 1;
		wait (hold_off);
		matrix.ready <= 0;
		repeat (200) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			for (int k = 0; k < 40; k++) begin
				case (mode)
					0: matrix.ready <= 1;
					1: matrix.ready <= ($urandom_range(0, 1) == 1);
					2: matrix.ready <= ($urandom_range(0, 7) == 0);
					default: matrix.ready <= (k % 3 != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((quat.valid && quat.ready) || (matrix.valid && matrix.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// verdict once everything has drained
	initial begin
		wait (stim_done);
		@(posedge clk iff pending == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
